[rtl/psc_pkg.sv]
// Shared types, widths and constants of the pressure sensor compensation unit.
package psc_pkg;

  localparam int COEF_W     = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 16;
  localparam int PRES_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_STAGES = 7;

  // Temperature reference point in centidegrees (20.00 degrees)
  localparam int TEMP_BASE = 2000;

  // Second-order correction: 3*dT^2/2^33 below the reference, else 7*dT^2/2^37
  localparam int T2_LOW_MUL    = 3;
  localparam int T2_HIGH_MUL   = 7;

  localparam int TEMP_MAX = 32767;
  localparam int TEMP_MIN = -32768;
  localparam int PRES_MAX = 8388607;
  localparam int PRES_MIN = -8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } psc_cfg_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } psc_coef_t;

endpackage

[rtl/psc_cfg_regs.sv]
// Calibration coefficient register file with a plain write port.
module psc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psc_pkg::COEF_W-1:0]     cfg_wdata,
  output psc_pkg::psc_coef_t             coef
);

  psc_pkg::psc_coef_t coef_r;
  psc_pkg::psc_coef_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr_en) begin
      case (psc_pkg::psc_cfg_reg_t'(cfg_index))
        psc_pkg::REG_SENS:     coef_nxt.sens     = cfg_wdata;
        psc_pkg::REG_OFF:      coef_nxt.off      = cfg_wdata;
        psc_pkg::REG_TCS:      coef_nxt.tcs      = cfg_wdata;
        psc_pkg::REG_TCO:      coef_nxt.tco      = cfg_wdata;
        psc_pkg::REG_TREF:     coef_nxt.tref     = cfg_wdata;
        psc_pkg::REG_TEMPSENS: coef_nxt.tempsens = cfg_wdata;
        default:               coef_nxt = coef_r;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

[rtl/psc_ctrl.sv]
// Stage valid bits and per-stage load enables of the compensation pipeline.
module psc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [psc_pkg::NUM_STAGES-1:0]  stage_en
);

  localparam int N = psc_pkg::NUM_STAGES;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] en;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < N; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign stage_en  = en;
  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];

  // Items in flight change only by transfers on either side
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $countones($past(v_r))
      + int'($past(in_valid && in_ready)) - int'($past(v_r[N-1] && out_ready))))
    else $error("pipeline lost or repeated an item");

  // A full, stalled pipe must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == {N{1'b1}} && !out_ready) |-> !in_ready)
    else $error("input taken into a full stalled pipe");

  // Refusing input means the first stage holds an item
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_r[0])
    else $error("input refused with an empty first stage");

endmodule

[rtl/psc_datapath.sv]
// Seven-stage compensation datapath: dT, products, terms, partial products, pressure.
module psc_datapath (
  input  logic                            clk,
  input  logic [psc_pkg::NUM_STAGES-1:0]  stage_en,
  input  psc_pkg::psc_coef_t              coef,
  input  logic [psc_pkg::RAW_W-1:0]       raw_pressure,
  input  logic [psc_pkg::RAW_W-1:0]       raw_temperature,
  output logic signed [psc_pkg::TEMP_W-1:0] temperature_centi,
  output logic signed [psc_pkg::PRES_W-1:0] pressure_tenth_mbar,
  output logic                            low_temp_branch
);

  // Stage 1: dT
  logic [23:0]        s1_d1_r;
  logic signed [24:0] s1_dt_r;
  logic signed [24:0] dt_nxt;

  assign dt_nxt = {1'b0, raw_temperature} - {1'b0, coef.tref, 8'b0};

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_d1_r <= raw_pressure;
      s1_dt_r <= dt_nxt;
    end
  end

  // Stage 2: coefficient products and dT squared
  logic signed [16:0] c6_s;
  logic signed [16:0] c4_s;
  logic signed [16:0] c3_s;
  logic signed [41:0] ptemp_nxt;
  logic signed [41:0] poff_nxt;
  logic signed [41:0] psens_nxt;
  logic signed [49:0] sq_nxt;
  logic [23:0]        s2_d1_r;
  logic signed [41:0] s2_ptemp_r;
  logic signed [41:0] s2_poff_r;
  logic signed [41:0] s2_psens_r;
  logic [47:0]        s2_sq_r;

  assign c6_s      = {1'b0, coef.tempsens};
  assign c4_s      = {1'b0, coef.tco};
  assign c3_s      = {1'b0, coef.tcs};
  assign ptemp_nxt = s1_dt_r * c6_s;
  assign poff_nxt  = s1_dt_r * c4_s;
  assign psens_nxt = s1_dt_r * c3_s;
  assign sq_nxt    = s1_dt_r * s1_dt_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_d1_r    <= s1_d1_r;
      s2_ptemp_r <= ptemp_nxt;
      s2_poff_r  <= poff_nxt;
      s2_psens_r <= psens_nxt;
      s2_sq_r    <= sq_nxt[47:0];
    end
  end

  // Stage 3: TEMP, OFF, SENS and both T2 candidates
  logic signed [41:0] ptemp_sh;
  logic signed [41:0] poff_sh;
  logic signed [41:0] psens_sh;
  logic signed [19:0] temp_nxt;
  logic signed [35:0] off_nxt;
  logic signed [34:0] sens_nxt;
  logic [50:0]        t2a_full;
  logic [50:0]        t2b_full;
  logic [23:0]        s3_d1_r;
  logic signed [19:0] s3_temp_r;
  logic signed [35:0] s3_off_r;
  logic signed [34:0] s3_sens_r;
  logic [16:0]        s3_t2a_r;
  logic [16:0]        s3_t2b_r;

  assign ptemp_sh = s2_ptemp_r >>> 23;
  assign poff_sh  = s2_poff_r >>> 7;
  assign psens_sh = s2_psens_r >>> 8;
  assign temp_nxt = ptemp_sh[19:0] + 20'(psc_pkg::TEMP_BASE);
  assign off_nxt  = poff_sh[35:0] + {4'b0, coef.off, 16'b0};
  assign sens_nxt = psens_sh[34:0] + {4'b0, coef.sens, 15'b0};
  assign t2a_full = {3'b0, s2_sq_r} * 51'(psc_pkg::T2_LOW_MUL);
  assign t2b_full = {3'b0, s2_sq_r} * 51'(psc_pkg::T2_HIGH_MUL);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s3_d1_r   <= s2_d1_r;
      s3_temp_r <= temp_nxt;
      s3_off_r  <= off_nxt;
      s3_sens_r <= sens_nxt;
      s3_t2a_r  <= t2a_full[49:33];
      s3_t2b_r  <= {3'b0, t2b_full[50:37]};
    end
  end

  // Stage 4: split D1*SENS, finish temperature
  logic signed [16:0] sens_hi;
  logic [17:0]        sens_lo;
  logic signed [24:0] d1_s;
  logic signed [41:0] ph_nxt;
  logic [41:0]        pl_nxt;
  logic               low_nxt;
  logic [16:0]        t2_sel;
  logic signed [20:0] tf;
  logic signed [15:0] tsat_nxt;
  logic signed [41:0] s4_ph_r;
  logic [41:0]        s4_pl_r;
  logic signed [35:0] s4_off_r;
  logic signed [15:0] s4_temp_r;
  logic               s4_low_r;

  assign sens_hi = s3_sens_r[34:18];
  assign sens_lo = s3_sens_r[17:0];
  assign d1_s    = {1'b0, s3_d1_r};
  assign ph_nxt  = d1_s * sens_hi;
  assign pl_nxt  = s3_d1_r * sens_lo;
  assign low_nxt = s3_temp_r < psc_pkg::TEMP_BASE;
  assign t2_sel  = low_nxt ? s3_t2a_r : s3_t2b_r;
  assign tf      = {s3_temp_r[19], s3_temp_r} - {4'b0, t2_sel};

  always_comb begin
    if (tf > psc_pkg::TEMP_MAX) begin
      tsat_nxt = 16'(psc_pkg::TEMP_MAX);
    end else if (tf < psc_pkg::TEMP_MIN) begin
      tsat_nxt = 16'(psc_pkg::TEMP_MIN);
    end else begin
      tsat_nxt = tf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s4_ph_r   <= ph_nxt;
      s4_pl_r   <= pl_nxt;
      s4_off_r  <= s3_off_r;
      s4_temp_r <= tsat_nxt;
      s4_low_r  <= low_nxt;
    end
  end

  // Stage 5: combine partial products
  logic signed [59:0] prod_nxt;
  logic signed [59:0] s5_prod_r;
  logic signed [35:0] s5_off_r;
  logic signed [15:0] s5_temp_r;
  logic               s5_low_r;

  assign prod_nxt = {s4_ph_r, 18'b0} + {18'b0, s4_pl_r};

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s5_prod_r <= prod_nxt;
      s5_off_r  <= s4_off_r;
      s5_temp_r <= s4_temp_r;
      s5_low_r  <= s4_low_r;
    end
  end

  // Stage 6: subtract OFF
  logic signed [38:0] prod_sh;
  logic signed [39:0] diff_nxt;
  logic signed [39:0] s6_diff_r;
  logic signed [15:0] s6_temp_r;
  logic               s6_low_r;

  assign prod_sh  = s5_prod_r[59:21];
  assign diff_nxt = {prod_sh[38], prod_sh} - {{4{s5_off_r[35]}}, s5_off_r};

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s6_diff_r <= diff_nxt;
      s6_temp_r <= s5_temp_r;
      s6_low_r  <= s5_low_r;
    end
  end

  // Stage 7: scale and saturate pressure, output register
  logic signed [24:0] p_sh;
  logic signed [23:0] psat_nxt;
  logic signed [23:0] s7_pres_r;
  logic signed [15:0] s7_temp_r;
  logic               s7_low_r;

  assign p_sh = s6_diff_r[39:15];

  always_comb begin
    if (p_sh > psc_pkg::PRES_MAX) begin
      psat_nxt = 24'(psc_pkg::PRES_MAX);
    end else if (p_sh < psc_pkg::PRES_MIN) begin
      psat_nxt = 24'(psc_pkg::PRES_MIN);
    end else begin
      psat_nxt = p_sh[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s7_pres_r <= psat_nxt;
      s7_temp_r <= s6_temp_r;
      s7_low_r  <= s6_low_r;
    end
  end

  assign temperature_centi   = s7_temp_r;
  assign pressure_tenth_mbar = s7_pres_r;
  assign low_temp_branch     = s7_low_r;

endmodule

[rtl/pressure_sensor_compensation_unit.sv]
// Top level of the pressure sensor compensation unit.
//
// Usage: load the six calibration coefficients through the cfg_ port
// (cfg_wr_en, cfg_index 0..5, cfg_wdata) while no reading is in flight;
// indices beyond the list are ignored. Then present raw D1/D2 pairs on the
// in_ channel; each transfer yields one result on the out_ channel carrying
// temperature in centidegrees, pressure in tenths of a millibar and the
// low-temperature correction flag. Both channels are valid/ready.
//
// Pipeline: seven register stages. Throughput: one reading per cycle while
// the receiver accepts results, set by the fully pipelined datapath (four
// parallel 25x17/25x25 multipliers in stage 2, a split 24x35 multiply over
// stages 4 and 5).
//
// Reset (rst_n, synchronous, active low) clears every coefficient to zero
// and empties the pipeline. When the receiver stalls, the output stage
// holds its result and upstream stages keep filling any bubbles; in_ready
// drops only once every stage holds a reading.
module pressure_sensor_compensation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [psc_pkg::RAW_W-1:0]           in_raw_pressure,
  input  logic [psc_pkg::RAW_W-1:0]           in_raw_temperature,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [psc_pkg::TEMP_W-1:0]   out_temperature_centi,
  output logic signed [psc_pkg::PRES_W-1:0]   out_pressure_tenth_mbar,
  output logic                                out_low_temp_branch,
  input  logic                                cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psc_pkg::COEF_W-1:0]          cfg_wdata
);

  psc_pkg::psc_coef_t                coef;
  logic [psc_pkg::NUM_STAGES-1:0]    stage_en;

  // Calibration registers; the user keeps them stable while readings flow (not enforced here)
  psc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // Valid bits and per-stage advance
  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  // Arithmetic stages; payload registers load only on their stage enable
  psc_datapath u_dp (
    .clk                 (clk),
    .stage_en            (stage_en),
    .coef                (coef),
    .raw_pressure        (in_raw_pressure),
    .raw_temperature     (in_raw_temperature),
    .temperature_centi   (out_temperature_centi),
    .pressure_tenth_mbar (out_pressure_tenth_mbar),
    .low_temp_branch     (out_low_temp_branch)
  );

endmodule
